[rtl/quaternion_arithmetic_unit_defines.svh]
// Assertion macros for the quaternion arithmetic unit
`ifndef QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define QAU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("qau assertion failed");
`define QAU_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("qau implication failed");
`else
`define QAU_ASSERT(lbl, clk, rstn, prop)
`define QAU_IMPLIES(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/qau_pkg.sv]
// Package: types, constants and step functions of the quaternion unit
package qau_pkg;

    localparam int CW     = 16;
    localparam int FB     = 14;
    localparam int NSTEP  = CW + 1;              // quotient bits and root bits
    localparam int SPS    = 3;                   // iteration steps per stage
    localparam int NIT    = (NSTEP + SPS - 1) / SPS;

    typedef enum logic [2:0] {
        FUNC_MUL  = 3'd0,
        FUNC_CONJ = 3'd1,
        FUNC_INV  = 3'd2,
        FUNC_NORM = 3'd3,
        FUNC_ZERO = 3'd4
    } t_func;

    // after the product stage
    typedef struct packed {
        logic [2:0]             func;
        logic [3:0][15:0]       a;
        logic [15:0][31:0]      p;     // p[4*i+j] = a_i * b_j
        logic [3:0][30:0]       sq;
    } t_sa;

    // after the sum stage
    typedef struct packed {
        logic [2:0]             func;
        logic [3:0][15:0]       mres;
        logic                   msat;
        logic                   zero;
        logic [32:0]            s;
        logic [3:0]             neg;
        logic [3:0][16:0]       m;
    } t_sb;

    // divider / root iteration stages
    typedef struct packed {
        logic [2:0]             func;
        logic [3:0][15:0]       mres;
        logic                   msat;
        logic                   zero;
        logic [32:0]            s;
        logic [3:0]             neg;
        logic [3:0]             dov;
        logic [3:0][33:0]       drem;
        logic [3:0][16:0]       dq;
        logic [20:0]            srem;
        logic [16:0]            sres;
    } t_it;

    // one restoring-divide step on all four lanes and one root digit
    function automatic t_it it_step(t_it x, int j);
        t_it         y;
        logic [33:0] rem2;
        logic [33:0] s34;
        logic [1:0]  pr;
        logic [20:0] rt;
        logic [20:0] tr;
        y   = x;
        s34 = {1'b0, x.s};
        for (int k = 0; k < 4; k++) begin
            rem2 = {x.drem[k][32:0], 1'b0};
            if (rem2 >= {1'b0, x.s}) begin
                y.drem[k] = rem2 - {1'b0, x.s};
                y.dq[k]   = {x.dq[k][15:0], 1'b1};
            end else begin
                y.drem[k] = rem2;
                y.dq[k]   = {x.dq[k][15:0], 1'b0};
            end
        end
        pr = 2'(s34 >> (2 * (NSTEP - 1 - j)));
        rt = {x.srem[18:0], pr};
        tr = {2'b00, x.sres, 2'b01};
        if (rt >= tr) begin
            y.srem = rt - tr;
            y.sres = {x.sres[15:0], 1'b1};
        end else begin
            y.srem = rt;
            y.sres = {x.sres[15:0], 1'b0};
        end
        return y;
    endfunction

    function automatic logic signed [33:0] sx(logic [31:0] p);
        return {{2{p[31]}}, p};
    endfunction

    // floor shift by FB and clamp; returns {sat, value}
    function automatic logic [16:0] clamp_sum(logic signed [33:0] v);
        logic signed [19:0] sh;
        sh = v[33:FB];
        if (sh > 20'sd32767) return {1'b1, 16'h7fff};
        else if (sh < -20'sd32768) return {1'b1, 16'h8000};
        else return {1'b0, sh[15:0]};
    endfunction

endpackage

[rtl/qau_in_if.sv]
// Input channel of the quaternion unit
interface qau_in_if import qau_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [15:0] a_w;
    logic [15:0] a_x;
    logic [15:0] a_y;
    logic [15:0] a_z;
    logic [15:0] b_w;
    logic [15:0] b_x;
    logic [15:0] b_y;
    logic [15:0] b_z;

    modport source (output valid, func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                    input ready);
    modport sink (input valid, func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  output ready);
endinterface

[rtl/qau_out_if.sv]
// Result channel of the quaternion unit
interface qau_out_if import qau_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] r_w;
    logic [15:0] r_x;
    logic [15:0] r_y;
    logic [15:0] r_z;
    logic [16:0] norm_out;
    logic        saturated;
    logic        zero_divide;
    logic        is_zero;

    modport source (output valid, r_w, r_x, r_y, r_z, norm_out, saturated,
                    zero_divide, is_zero, input ready);
    modport sink (input valid, r_w, r_x, r_y, r_z, norm_out, saturated,
                  zero_divide, is_zero, output ready);
endinterface

[rtl/quaternion_arithmetic_unit.sv]
// Quaternion ALU top level: Q2.14 product, conjugate, inverse, norm, zero test
//
// Usage: i_item carries func and quaternions a, b under valid/ready; one
// result item leaves on o_result for every item taken in.
// From acceptance to the result showing on o_result, an item passes through:
// a product stage (20 16x16 multipliers), a sum/saturate stage, six
// divide/root stages of up to three restoring steps each (17 quotient bits
// on four lanes and 17 root digits), and a registered output formatting stage.
// Throughput is one item per cycle while the receiver keeps ready high; every stage holds its own valid bit.
// Each stage's ready is its own emptiness or the next stage's ready, so a
// stalled receiver freezes only the stages that are full and bubbles fill
// up behind it; nothing is dropped or repeated.
// Reset (i_rst_n low at a clock edge) clears all valid bits; payload
// registers are not reset.
// Inverse of a zero quaternion gives zeros with zero_divide set.
`include "quaternion_arithmetic_unit_defines.svh"

module quaternion_arithmetic_unit import qau_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qau_in_if.sink    i_item,
    qau_out_if.source o_result
);

    // ---------------- stage registers ----------------
    t_sa         r_a;
    logic        r_av;
    t_sb         r_b;
    t_sb         n_b;
    logic        r_bv;
    t_it         r_c [NIT];
    t_it         n_c [NIT];
    logic [NIT-1:0] r_cv;

    logic [15:0] r_rw, r_rx, r_ry, r_rz;
    logic [16:0] r_norm;
    logic        r_sat, r_zdiv, r_zero;
    logic        r_ov;

    logic [15:0] n_rw, n_rx, n_ry, n_rz;
    logic [16:0] n_norm;
    logic        n_sat, n_zdiv, n_zero;

    // ---------------- ready chain ----------------
    logic           rdy_o;
    logic [NIT-1:0] rdy_c;
    logic           rdy_b;
    logic           rdy_a;

    always_comb begin
        rdy_o = !r_ov || o_result.ready;
        for (int k = NIT - 1; k >= 0; k--) begin
            if (k == NIT - 1) rdy_c[k] = !r_cv[k] || rdy_o;
            else              rdy_c[k] = !r_cv[k] || rdy_c[k+1];
        end
        rdy_b = !r_bv || rdy_c[0];
        rdy_a = !r_av || rdy_b;
    end

    assign i_item.ready = rdy_a;

    // ---------------- stage A: products and squares ----------------
    logic signed [15:0] in_a [4];
    logic signed [15:0] in_b [4];
    assign in_a[0] = i_item.a_w;
    assign in_a[1] = i_item.a_x;
    assign in_a[2] = i_item.a_y;
    assign in_a[3] = i_item.a_z;
    assign in_b[0] = i_item.b_w;
    assign in_b[1] = i_item.b_x;
    assign in_b[2] = i_item.b_y;
    assign in_b[3] = i_item.b_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (rdy_a) begin
            r_av <= i_item.valid;
        end
        if (rdy_a) begin
            r_a.func <= i_item.func;
            for (int i = 0; i < 4; i++) begin
                r_a.a[i] <= in_a[i];
                r_a.sq[i] <= 31'(in_a[i] * in_a[i]);
                for (int j = 0; j < 4; j++) begin
                    r_a.p[4*i+j] <= 32'(in_a[i] * in_b[j]);
                end
            end
        end
    end

    // ---------------- stage B: sums, saturation, conjugate ----------------
    logic signed [33:0] sum_c [4];
    logic [16:0]        cl [4];
    logic signed [16:0] cj [4];

    always_comb begin
        // Hamilton product rows
        sum_c[0] = sx(r_a.p[0]) - sx(r_a.p[5]) - sx(r_a.p[10]) - sx(r_a.p[15]);
        sum_c[1] = sx(r_a.p[1]) + sx(r_a.p[4]) + sx(r_a.p[11]) - sx(r_a.p[14]);
        sum_c[2] = sx(r_a.p[2]) + sx(r_a.p[8]) + sx(r_a.p[13]) - sx(r_a.p[7]);
        sum_c[3] = sx(r_a.p[3]) + sx(r_a.p[12]) + sx(r_a.p[6]) - sx(r_a.p[9]);
        for (int i = 0; i < 4; i++) begin
            cl[i] = clamp_sum(sum_c[i]);
            // divide operand: w as is, vector part negated
            if (i == 0) cj[i] = {r_a.a[i][15], r_a.a[i]};
            else        cj[i] = -{r_a.a[i][15], r_a.a[i]};
        end

        n_b.func = r_a.func;
        n_b.s    = {2'b00, r_a.sq[0]} + {2'b00, r_a.sq[1]}
                 + {2'b00, r_a.sq[2]} + {2'b00, r_a.sq[3]};
        n_b.zero = (r_a.a == '0);
        for (int i = 0; i < 4; i++) begin
            n_b.neg[i] = cj[i][16];
            n_b.m[i]   = cj[i][16] ? 17'(-cj[i]) : 17'(cj[i]);
        end

        n_b.msat = 1'b0;
        if (r_a.func == FUNC_CONJ) begin
            n_b.mres[0] = r_a.a[0];
            for (int i = 1; i < 4; i++) begin
                // negating the most negative value pins at the top
                if (cj[i] == 17'sd32768) begin
                    n_b.mres[i] = 16'h7fff;
                    n_b.msat    = 1'b1;
                end else begin
                    n_b.mres[i] = cj[i][15:0];
                end
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                n_b.mres[i] = cl[i][15:0];
            end
            n_b.msat = cl[0][16] | cl[1][16] | cl[2][16] | cl[3][16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
        end else if (rdy_b) begin
            r_bv <= r_av;
        end
        if (rdy_b) begin
            r_b <= n_b;
        end
    end

    // ---------------- stages C: divide and root iterations ----------------
    t_it            c_init;
    t_it            c_in [NIT];
    logic [NIT-1:0] cv_in;

    assign cv_in = {r_cv[NIT-2:0], r_bv};

    always_comb begin
        c_init.func = r_b.func;
        c_init.mres = r_b.mres;
        c_init.msat = r_b.msat;
        c_init.zero = r_b.zero;
        c_init.s    = r_b.s;
        c_init.neg  = r_b.neg;
        for (int i = 0; i < 4; i++) begin
            // quotient of 2^17 or more means saturation right away
            c_init.dov[i]  = ({6'b0, r_b.m[i], 11'b0} >= {1'b0, r_b.s});
            c_init.drem[i] = {6'b0, r_b.m[i], 11'b0};
            c_init.dq[i]   = '0;
        end
        c_init.srem = '0;
        c_init.sres = '0;

        c_in[0] = c_init;
        for (int k = 1; k < NIT; k++) begin
            c_in[k] = r_c[k-1];
        end

        for (int k = 0; k < NIT; k++) begin
            n_c[k] = c_in[k];
            for (int t = 0; t < SPS; t++) begin
                if (k * SPS + t < NSTEP) n_c[k] = it_step(n_c[k], k * SPS + t);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NIT; k++) begin
            if (!i_rst_n) begin
                r_cv[k] <= 1'b0;
            end else if (rdy_c[k]) begin
                r_cv[k] <= cv_in[k];
            end
            if (rdy_c[k]) begin
                r_c[k] <= n_c[k];
            end
        end
    end

    // ---------------- output formatting ----------------
    t_it         fin;
    logic [16:0] lim  [4];
    logic [16:0] qv   [4];
    logic        ovr  [4];
    logic [15:0] inv  [4];

    always_comb begin
        fin = r_c[NIT-1];
        for (int i = 0; i < 4; i++) begin
            lim[i] = fin.neg[i] ? 17'd32768 : 17'd32767;
            ovr[i] = fin.dov[i] || (fin.dq[i] > lim[i]);
            qv[i]  = ovr[i] ? lim[i] : fin.dq[i];
            inv[i] = fin.neg[i] ? 16'(-qv[i]) : qv[i][15:0];
        end

        n_rw   = '0;
        n_rx   = '0;
        n_ry   = '0;
        n_rz   = '0;
        n_norm = '0;
        n_sat  = 1'b0;
        n_zdiv = 1'b0;
        n_zero = 1'b0;
        unique case (fin.func)
            FUNC_MUL, FUNC_CONJ: begin
                n_rw  = fin.mres[0];
                n_rx  = fin.mres[1];
                n_ry  = fin.mres[2];
                n_rz  = fin.mres[3];
                n_sat = fin.msat;
            end
            FUNC_INV: begin
                if (fin.s == '0) begin
                    n_zdiv = 1'b1;
                end else begin
                    n_rw  = inv[0];
                    n_rx  = inv[1];
                    n_ry  = inv[2];
                    n_rz  = inv[3];
                    n_sat = ovr[0] | ovr[1] | ovr[2] | ovr[3];
                end
            end
            FUNC_NORM: n_norm = fin.sres;
            FUNC_ZERO: n_zero = fin.zero;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (rdy_o) begin
            r_ov <= r_cv[NIT-1];
        end
        if (rdy_o) begin
            r_rw   <= n_rw;
            r_rx   <= n_rx;
            r_ry   <= n_ry;
            r_rz   <= n_rz;
            r_norm <= n_norm;
            r_sat  <= n_sat;
            r_zdiv <= n_zdiv;
            r_zero <= n_zero;
        end
    end

    assign o_result.valid       = r_ov;
    assign o_result.r_w         = r_rw;
    assign o_result.r_x         = r_rx;
    assign o_result.r_y         = r_ry;
    assign o_result.r_z         = r_rz;
    assign o_result.norm_out    = r_norm;
    assign o_result.saturated   = r_sat;
    assign o_result.zero_divide = r_zdiv;
    assign o_result.is_zero     = r_zero;

    // ---------------- assertions ----------------
    `QAU_IMPLIES(a_zdiv_clear, i_clk, i_rst_n, r_ov && r_zdiv,
        r_rw == '0 && r_rx == '0 && r_ry == '0 && r_rz == '0 && !r_sat)
    `QAU_IMPLIES(a_norm_alone, i_clk, i_rst_n, r_ov && r_norm != '0,
        r_rw == '0 && r_rx == '0 && r_ry == '0 && r_rz == '0 && !r_zero)
    `QAU_ASSERT(a_empty_ready, i_clk, i_rst_n, !r_ov |-> rdy_a)
    `QAU_ASSERT(a_stall_hold, i_clk, i_rst_n,
        r_ov && !o_result.ready |=> r_ov && $stable(r_rw) && $stable(r_norm))

endmodule
